// ----- rtl/core/goertzel_tone_bank_defines.svh -----
// Assertion macros for the RTL; clk and rst_n are taken from the
// module that uses them.
`ifndef GOERTZEL_TONE_BANK_DEFINES_SVH
`define GOERTZEL_TONE_BANK_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define GTB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define GTB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/gtb_pkg.sv -----
`default_nettype none
package gtb_pkg;

  localparam int NUM_BINS    = 4;
  localparam int SAMPLE_BITS = 16;
  localparam int STATE_BITS  = 48;
  localparam int COEF_BITS   = 18;
  localparam int FRAC_BITS   = 16;
  localparam int POWER_BITS  = 62;
  localparam int BIN_BITS    = 2;
  localparam int NBINS_BITS  = 3;
  localparam int ACC_BITS    = 128;
  localparam int TPROD_BITS  = COEF_BITS + STATE_BITS;
  localparam int CNT_BITS    = 6;
  localparam int CFG_IDX_BITS = 3;

  // Register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_COEF0 = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_COEF1 = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_COEF2 = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_COEF3 = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BINS  = 3'd4;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          block_end;
  } in_t;

  typedef struct packed {
    logic [BIN_BITS-1:0]   bin_index;
    logic [POWER_BITS-1:0] power;
    logic                  last_bin;
  } out_t;

  // Command to the serial multiplier
  typedef struct packed {
    logic                start;
    logic                clr;
    logic [CNT_BITS-1:0] last_idx;
  } mul_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_sts_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_REC_GO,
    ST_REC_WAIT,
    ST_REC_FIN,
    ST_T_GO,
    ST_T_WAIT,
    ST_SQ1_GO,
    ST_SQ1_WAIT,
    ST_SQ2_GO,
    ST_SQ2_WAIT,
    ST_X_GO,
    ST_X_WAIT,
    ST_PWR_FIN
  } state_t;

endpackage
`default_nettype wire

// ----- rtl/core/gtb_serial_mul.sv -----
`default_nettype none
// Bit-serial shift-add multiplier, one multiplier bit per cycle, LSB first.
// The top bit of the multiplier carries negative weight (two's complement).
module gtb_serial_mul (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire gtb_pkg::mul_cmd_t                    cmd,
  input  wire logic signed [gtb_pkg::ACC_BITS-1:0]  mcand,
  input  wire logic [gtb_pkg::STATE_BITS-1:0]       mplier,
  output gtb_pkg::mul_sts_t                         sts,
  output logic signed [gtb_pkg::ACC_BITS-1:0]       acc
);

  logic signed [gtb_pkg::ACC_BITS-1:0]   acc_r, acc_nxt;
  logic signed [gtb_pkg::ACC_BITS-1:0]   mc_r, mc_nxt;
  logic [gtb_pkg::STATE_BITS-1:0]        mp_r, mp_nxt;
  logic [gtb_pkg::CNT_BITS-1:0]          cnt_r, cnt_nxt;
  logic                                  busy_r, busy_nxt;
  logic                                  last_bit;

  assign last_bit = (cnt_r == '0);

  // Step logic
  always_comb begin
    acc_nxt  = acc_r;
    mc_nxt   = mc_r;
    mp_nxt   = mp_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (cmd.start) begin
      acc_nxt  = cmd.clr ? '0 : acc_r;
      mc_nxt   = mcand;
      mp_nxt   = mplier;
      cnt_nxt  = cmd.last_idx;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (mp_r[0]) begin
        acc_nxt = last_bit ? (acc_r - mc_r) : (acc_r + mc_r);
      end
      mc_nxt  = mc_r <<< 1;
      mp_nxt  = mp_r >> 1;
      cnt_nxt = cnt_r - 1'b1;
      if (last_bit) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Datapath registers, no reset
  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    mc_r  <= mc_nxt;
    mp_r  <= mp_nxt;
  end

  assign acc = acc_r;
  assign sts = '{busy: busy_r, done: (busy_r && last_bit && !cmd.start)};

endmodule
`default_nettype wire

// ----- rtl/core/goertzel_tone_bank.sv -----
`default_nettype none
// Channel  Dir  Payload                      Transfer
// in_      in   gtb_pkg::in_t  (sample,end)  in_valid & in_ready
// out_     out  gtb_pkg::out_t (bin,power)   out_valid & out_ready
// cfg_     in   index 3b, data 18b           cfg_valid & cfg_ready (always ready)
//
// Each sample runs all 4 bins in turn: launch, 18 serial coef steps, update.
// A block-end sample then does, per reported bin, c*s1, s1^2, s2^2
// and t*s2 through the one bit-serial multiplier, then rounding/saturation.
// One item at a time: in_ready is high only while the sequencer is idle.
// Reset (synchronous, rst_n low) clears delay state, coefficients to 0,
// bins_in_use to 4. A stalled result holds the sequencer until it transfers.
`include "goertzel_tone_bank_defines.svh"
module goertzel_tone_bank (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire gtb_pkg::in_t                          in_data,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output gtb_pkg::out_t                              out_data,
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [gtb_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  wire logic [gtb_pkg::COEF_BITS-1:0]         cfg_data
);

  localparam int ACC  = gtb_pkg::ACC_BITS;
  localparam int SB   = gtb_pkg::STATE_BITS;
  localparam int FB   = gtb_pkg::FRAC_BITS;
  localparam int TB   = gtb_pkg::TPROD_BITS;
  localparam int NB   = gtb_pkg::NUM_BINS;
  localparam int RW   = TB + 6;           // recurrence sum width
  localparam int PW   = ACC - FB;         // rounded power width

  gtb_pkg::state_t state_r, state_nxt;

  logic signed [gtb_pkg::COEF_BITS-1:0]   coef_r [NB];
  logic [gtb_pkg::NBINS_BITS-1:0]         bins_r;
  logic signed [SB-1:0]                   s1_r [NB];
  logic signed [SB-1:0]                   s2_r [NB];
  logic [gtb_pkg::BIN_BITS-1:0]           bin_r, bin_nxt;
  logic signed [gtb_pkg::SAMPLE_BITS-1:0] x_r;
  logic                                   end_r;
  logic signed [TB-1:0]                   t_r;
  gtb_pkg::out_t                          out_r;
  logic                                   out_valid_r;

  gtb_pkg::mul_cmd_t                      mcmd;
  gtb_pkg::mul_sts_t                      msts;
  logic signed [ACC-1:0]                  mcand;
  logic [SB-1:0]                          mplier;
  logic signed [ACC-1:0]                  acc;

  logic signed [SB-1:0]                   s1_cur, s2_cur;
  logic [gtb_pkg::NBINS_BITS-1:0]         bins_eff;
  logic                                   bin_top, bin_last_rep;
  logic                                   slot_free;
  logic                                   rec_we, pwr_we, clr_all;
  logic signed [RW-1:0]                   rec_sum;
  logic signed [SB-1:0]                   rec_sat;
  logic signed [ACC-1:0]                  pwr_rnd;
  logic signed [PW-1:0]                   pwr_sh;
  logic [gtb_pkg::POWER_BITS-1:0]         pwr_sat;

  function automatic logic signed [SB-1:0] s1_max();
    return {1'b0, {(SB-1){1'b1}}};
  endfunction

  assign in_ready  = (state_r == gtb_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign slot_free = !out_valid_r || out_ready;

  assign s1_cur = s1_r[bin_r];
  assign s2_cur = s2_r[bin_r];

  // Effective bin count: 0 acts as 1, above NUM_BINS acts as NUM_BINS
  always_comb begin
    if (bins_r == '0) begin
      bins_eff = 3'd1;
    end else if (bins_r > gtb_pkg::NBINS_BITS'(NB)) begin
      bins_eff = gtb_pkg::NBINS_BITS'(NB);
    end else begin
      bins_eff = bins_r;
    end
  end
  assign bin_top      = (bin_r == gtb_pkg::BIN_BITS'(NB - 1));
  assign bin_last_rep = ({1'b0, bin_r} == (bins_eff - 1'b1));

  // Recurrence finish: round c*s1, add x, subtract s2, saturate
  always_comb begin
    logic signed [RW-1:0] prod;
    logic signed [RW-1:0] rnd;
    prod    = acc[RW-1:0];
    rnd     = (prod + RW'(1 <<< (FB - 1))) >>> FB;
    rec_sum = rnd + RW'(x_r) - RW'(s2_cur);
    if (rec_sum > RW'(s1_max())) begin
      rec_sat = s1_max();
    end else if (rec_sum < -RW'(s1_max()) - 1) begin
      rec_sat = ~s1_max();
    end else begin
      rec_sat = rec_sum[SB-1:0];
    end
  end

  // Power finish: round, clamp to [0, 2^62-1]
  always_comb begin
    pwr_rnd = acc + ACC'(1 <<< (FB - 1));
    pwr_sh  = pwr_rnd[ACC-1:FB];
    if (pwr_sh[PW-1]) begin
      pwr_sat = '0;
    end else if (|pwr_sh[PW-2:gtb_pkg::POWER_BITS]) begin
      pwr_sat = '1;
    end else begin
      pwr_sat = pwr_sh[gtb_pkg::POWER_BITS-1:0];
    end
  end

  // Sequencer: next state and multiplier launches
  always_comb begin
    state_nxt     = state_r;
    bin_nxt       = bin_r;
    mcmd          = '0;
    mcand         = '0;
    mplier        = '0;
    rec_we        = 1'b0;
    pwr_we        = 1'b0;
    clr_all       = 1'b0;
    case (state_r)
      gtb_pkg::ST_IDLE: begin
        if (in_valid) begin
          bin_nxt   = '0;
          state_nxt = gtb_pkg::ST_REC_GO;
        end
      end
      gtb_pkg::ST_REC_GO, gtb_pkg::ST_T_GO: begin
        mcmd.start    = 1'b1;
        mcmd.clr      = 1'b1;
        mcmd.last_idx = gtb_pkg::CNT_BITS'(gtb_pkg::COEF_BITS - 1);
        mcand         = ACC'(s1_cur);
        mplier        = SB'(coef_r[bin_r]);
        state_nxt     = (state_r == gtb_pkg::ST_REC_GO) ? gtb_pkg::ST_REC_WAIT
                                                        : gtb_pkg::ST_T_WAIT;
      end
      gtb_pkg::ST_REC_WAIT: begin
        if (msts.done) state_nxt = gtb_pkg::ST_REC_FIN;
      end
      gtb_pkg::ST_REC_FIN: begin
        rec_we = 1'b1;
        if (bin_top) begin
          bin_nxt   = '0;
          state_nxt = end_r ? gtb_pkg::ST_T_GO : gtb_pkg::ST_IDLE;
        end else begin
          bin_nxt   = bin_r + 1'b1;
          state_nxt = gtb_pkg::ST_REC_GO;
        end
      end
      gtb_pkg::ST_T_WAIT: begin
        if (msts.done) state_nxt = gtb_pkg::ST_SQ1_GO;
      end
      gtb_pkg::ST_SQ1_GO: begin
        mcmd.start    = 1'b1;
        mcmd.clr      = 1'b1;
        mcmd.last_idx = gtb_pkg::CNT_BITS'(SB - 1);
        mcand         = ACC'(s1_cur) <<< FB;
        mplier        = s1_cur;
        state_nxt     = gtb_pkg::ST_SQ1_WAIT;
      end
      gtb_pkg::ST_SQ1_WAIT: begin
        if (msts.done) state_nxt = gtb_pkg::ST_SQ2_GO;
      end
      gtb_pkg::ST_SQ2_GO: begin
        mcmd.start    = 1'b1;
        mcmd.last_idx = gtb_pkg::CNT_BITS'(SB - 1);
        mcand         = ACC'(s2_cur) <<< FB;
        mplier        = s2_cur;
        state_nxt     = gtb_pkg::ST_SQ2_WAIT;
      end
      gtb_pkg::ST_SQ2_WAIT: begin
        if (msts.done) state_nxt = gtb_pkg::ST_X_GO;
      end
      gtb_pkg::ST_X_GO: begin
        mcmd.start    = 1'b1;
        mcmd.last_idx = gtb_pkg::CNT_BITS'(SB - 1);
        mcand         = -ACC'(t_r);
        mplier        = s2_cur;
        state_nxt     = gtb_pkg::ST_X_WAIT;
      end
      gtb_pkg::ST_X_WAIT: begin
        if (msts.done) state_nxt = gtb_pkg::ST_PWR_FIN;
      end
      gtb_pkg::ST_PWR_FIN: begin
        if (slot_free) begin
          pwr_we = 1'b1;
          if (bin_last_rep) begin
            clr_all   = 1'b1;
            state_nxt = gtb_pkg::ST_IDLE;
          end else begin
            bin_nxt   = bin_r + 1'b1;
            state_nxt = gtb_pkg::ST_T_GO;
          end
        end
      end
      default: state_nxt = gtb_pkg::ST_IDLE;
    endcase
  end

  gtb_serial_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (mcmd),
    .mcand  (mcand),
    .mplier (mplier),
    .sts    (msts),
    .acc    (acc)
  );

  // Control, configuration and delay state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gtb_pkg::ST_IDLE;
      bin_r       <= '0;
      out_valid_r <= 1'b0;
      bins_r      <= gtb_pkg::NBINS_BITS'(NB);
      for (int k = 0; k < NB; k++) begin
        coef_r[k] <= '0;
        s1_r[k]   <= '0;
        s2_r[k]   <= '0;
      end
    end else begin
      state_r <= state_nxt;
      bin_r   <= bin_nxt;
      if (pwr_we) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid) begin
        case (cfg_index)
          gtb_pkg::CFG_COEF0: coef_r[0] <= cfg_data;
          gtb_pkg::CFG_COEF1: coef_r[1] <= cfg_data;
          gtb_pkg::CFG_COEF2: coef_r[2] <= cfg_data;
          gtb_pkg::CFG_COEF3: coef_r[3] <= cfg_data;
          gtb_pkg::CFG_BINS:  bins_r    <= cfg_data[gtb_pkg::NBINS_BITS-1:0];
          default: ;
        endcase
      end
      if (clr_all) begin
        for (int k = 0; k < NB; k++) begin
          s1_r[k] <= '0;
          s2_r[k] <= '0;
        end
      end else if (rec_we) begin
        s2_r[bin_r] <= s1_cur;
        s1_r[bin_r] <= rec_sat;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      x_r   <= in_data.sample;
      end_r <= in_data.block_end;
    end
    // c*s1 is complete once the multiplier has finished its last step
    if (state_r == gtb_pkg::ST_SQ1_GO) begin
      t_r <= acc[TB-1:0];
    end
    if (pwr_we) begin
      out_r.bin_index <= bin_r;
      out_r.power     <= pwr_sat;
      out_r.last_bin  <= bin_last_rep;
    end
  end

  // Assertions
  `GTB_ASSERT_IMP(a_done_in_wait, msts.done,
    (state_r == gtb_pkg::ST_REC_WAIT) || (state_r == gtb_pkg::ST_T_WAIT) ||
    (state_r == gtb_pkg::ST_SQ1_WAIT) || (state_r == gtb_pkg::ST_SQ2_WAIT) ||
    (state_r == gtb_pkg::ST_X_WAIT), "multiplier done outside a wait state")
  `GTB_ASSERT_NXT(a_in_starts, in_valid && in_ready,
    (state_r == gtb_pkg::ST_REC_GO) && (bin_r == '0), "accepted sample not started")
  `GTB_ASSERT_NXT(a_pwr_out, pwr_we, out_valid_r, "result written but not valid")
  `GTB_ASSERT_IMP(a_no_launch_busy, mcmd.start, !msts.busy, "multiplier relaunched while busy")

endmodule
`default_nettype wire

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
`default_nettype none

module tb_top;
  import gtb_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 120;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [COEF_BITS-1:0] cfg_data;

  // tone bank mirror: coefficients, bin count, delay pairs
  logic signed [COEF_BITS-1:0] coef_mirror [NUM_BINS];
  logic [NBINS_BITS-1:0] bins_mirror;
  logic signed [STATE_BITS-1:0] s1_mirror [NUM_BINS];
  logic signed [STATE_BITS-1:0] s2_mirror [NUM_BINS];

  out_t pending_power [$];
  int send_idle_pct;
  int recv_idle_pct;
  int err_count;
  int sample_count;
  int block_count;
  int power_count;
  longint cycle_count;

  goertzel_tone_bank uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout at %0t", $time);
      $display("goertzel_tone_bank verification failed");
      $finish;
    end
  end

  // receiver backpressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // compare each result transfer with the oldest expected power
  always @(posedge clk) begin
    out_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      power_count++;
      if (pending_power.size() == 0) begin
        err_count++;
        $display("%0t unexpected result: exp none act %p", $time, out_data);
      end else begin
        exp_r = pending_power.pop_front();
        if (out_data.bin_index !== exp_r.bin_index) begin
          err_count++;
          $display("%0t bin_index mismatch: exp %0d act %0d", $time,
                   exp_r.bin_index, out_data.bin_index);
        end
        if (out_data.power !== exp_r.power) begin
          err_count++;
          $display("%0t power mismatch (bin %0d): exp %0d act %0d", $time,
                   exp_r.bin_index, exp_r.power, out_data.power);
        end
        if (out_data.last_bin !== exp_r.last_bin) begin
          err_count++;
          $display("%0t last_bin mismatch (bin %0d): exp %0d act %0d", $time,
                   exp_r.bin_index, exp_r.last_bin, out_data.last_bin);
        end
      end
    end
  end

  // advance every bin by one sample; on block end queue the bin powers
  function automatic void goertzel_update(in_t item);
    logic signed [127:0] c_w, s1_w, s2_w, acc, pw;
    logic signed [127:0] smax, smin, pmax;
    int n;
    smax = (128'sd1 <<< (STATE_BITS - 1)) - 128'sd1;
    smin = -smax - 128'sd1;
    pmax = (128'sd1 <<< POWER_BITS) - 128'sd1;
    for (int k = 0; k < NUM_BINS; k++) begin
      c_w = coef_mirror[k];
      s1_w = s1_mirror[k];
      s2_w = s2_mirror[k];
      acc = ((c_w * s1_w + 128'sd32768) >>> FRAC_BITS) + 128'(item.sample) - s2_w;
      if (acc > smax) acc = smax;
      if (acc < smin) acc = smin;
      s2_mirror[k] = s1_mirror[k];
      s1_mirror[k] = acc[STATE_BITS-1:0];
    end
    if (!item.block_end) return;
    n = bins_mirror;
    if (n < 1) n = 1;
    if (n > NUM_BINS) n = NUM_BINS;
    for (int k = 0; k < n; k++) begin
      out_t r;
      c_w = coef_mirror[k];
      s1_w = s1_mirror[k];
      s2_w = s2_mirror[k];
      pw = (((s1_w * s1_w + s2_w * s2_w) <<< FRAC_BITS) - c_w * s1_w * s2_w
            + 128'sd32768) >>> FRAC_BITS;
      if (pw < 0) pw = 0;
      if (pw > pmax) pw = pmax;
      r.bin_index = k[BIN_BITS-1:0];
      r.power = pw[POWER_BITS-1:0];
      r.last_bin = (k == n - 1);
      pending_power.push_back(r);
    end
    for (int k = 0; k < NUM_BINS; k++) begin
      s1_mirror[k] = '0;
      s2_mirror[k] = '0;
    end
    block_count++;
  endfunction

  task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] smp, input logic fin);
    int gap;
    gap = 0;
    if ($urandom_range(99) < send_idle_pct) gap = $urandom_range(6, 1);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{sample: smp, block_end: fin};
    do @(posedge clk); while (!in_ready);
    sample_count++;
    goertzel_update(in_data);
  endtask

  // block idle: all powers back and the sequencer finished
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_power.size() != 0 || !in_ready) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [COEF_BITS-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_BINS) bins_mirror = val[NBINS_BITS-1:0];
    else if (idx <= CFG_COEF3) coef_mirror[idx[BIN_BITS-1:0]] = val;
  endtask

  task automatic set_coefs(input logic [COEF_BITS-1:0] c0, input logic [COEF_BITS-1:0] c1,
                           input logic [COEF_BITS-1:0] c2, input logic [COEF_BITS-1:0] c3);
    write_reg(CFG_COEF0, c0);
    write_reg(CFG_COEF1, c1);
    write_reg(CFG_COEF2, c2);
    write_reg(CFG_COEF3, c3);
  endtask

  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(7))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return '0;
      default: return SAMPLE_BITS'($urandom());
    endcase
  endfunction

  function automatic logic [COEF_BITS-1:0] pick_coef();
    case ($urandom_range(5))
      0: return 18'h1ffff;
      1: return 18'h20000;
      default: return COEF_BITS'($urandom());
    endcase
  endfunction

  // reset values: zero coefficients, all four bins
  task automatic test_reset_values();
    send_sample(16'sh7fff, 1'b1);
    send_sample(-16'sd32768, 1'b1);
    wait_idle();
  endtask

  // coefficient and sample extremes over multi-sample and single-sample blocks
  task automatic test_extremes();
    set_coefs(18'h1ffff, 18'h20000, 18'h10000, 18'h30000);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh7fff, 1'b1);
    send_sample(-16'sd32768, 1'b0);
    send_sample(16'sh7fff, 1'b0);
    send_sample(-16'sd32768, 1'b1);
    send_sample(16'sd0, 1'b1);
    wait_idle();
  endtask

  // bin count including zero, above range, and ignored register indexes
  task automatic test_bin_count();
    logic [NBINS_BITS-1:0] counts [7] = '{3'd1, 3'd2, 3'd3, 3'd0, 3'd5, 3'd7, 3'd4};
    write_reg(3'd5, 18'h3ffff);
    write_reg(3'd6, 18'h00001);
    write_reg(3'd7, 18'h2aaaa);
    foreach (counts[i]) begin
      write_reg(CFG_BINS, {15'd0, counts[i]});
      send_sample(16'sd1234, 1'b0);
      send_sample(-16'sd999, 1'b1);
      wait_idle();
    end
  endtask

  // coefficient change between samples of one block
  task automatic test_midblock_write();
    send_sample(16'sd20000, 1'b0);
    wait_idle();
    set_coefs(18'h0c000, 18'h3c000, 18'h1ffff, 18'h00000);
    send_sample(-16'sd15000, 1'b0);
    send_sample(16'sd7, 1'b1);
    wait_idle();
  endtask

  // random blocks under one idling mode
  task automatic test_random_blocks(input int n_samples, input int s_pct, input int r_pct);
    int sent, len;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    sent = 0;
    while (sent < n_samples) begin
      if ($urandom_range(2) == 0) begin
        set_coefs(pick_coef(), pick_coef(), pick_coef(), pick_coef());
        write_reg(CFG_BINS, COEF_BITS'($urandom_range(7)));
      end
      len = $urandom_range(6, 1);
      for (int i = 0; i < len; i++)
        send_sample(pick_sample(), (i == len - 1));
      sent += len;
      wait_idle();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    out_ready = 1'b0;
    err_count = 0;
    sample_count = 0;
    block_count = 0;
    power_count = 0;
    cycle_count = 0;
    send_idle_pct = 26;
    recv_idle_pct = 51;
    for (int k = 0; k < NUM_BINS; k++) begin
      coef_mirror[k] = '0;
      s1_mirror[k] = '0;
      s2_mirror[k] = '0;
    end
    bins_mirror = 3'd4;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_values();
    test_extremes();
    test_bin_count();
    test_midblock_write();
    test_random_blocks(40, 26, 51);
    test_random_blocks(40, 51, 26);
    test_random_blocks(40, 0, 0);

    wait_idle();
    $display("covered %0d samples in %0d blocks, %0d bin powers checked",
             sample_count, block_count, power_count);
    $display("idle mixes: sender 26/receiver 51, swapped, and none");
    if (err_count == 0 && pending_power.size() == 0) begin
      $display("goertzel_tone_bank verification clean");
    end else begin
      $display("goertzel_tone_bank verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/gtb_pkg.sv
rtl/core/gtb_serial_mul.sv
rtl/core/goertzel_tone_bank.sv
dv/tb_top.sv
